### sv/cds_pkg.sv
// shared types, codes and calendar functions for the calendar date stepper
`default_nettype none

package cds_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 16;
    localparam int WEEKDAY_W = 3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RETREAT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

    // months
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // weekdays
    localparam logic [WEEKDAY_W-1:0] WD_MON = 3'd1;
    localparam logic [WEEKDAY_W-1:0] WD_SUN = 3'd7;

    // day constants
    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAY_28    = 5'd28;
    localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
    localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
    localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

    // divisibility by 25: multiply by the inverse of 25 mod 2^16, then compare
    localparam logic [YEAR_W-1:0] INV25   = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [DAY_W-1:0]     load_day;
        logic [MONTH_W-1:0]   load_month;
        logic [YEAR_W-1:0]    load_year;
        logic [WEEKDAY_W-1:0] load_weekday;
    } cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        logic [WEEKDAY_W-1:0] weekday;
    } date_t;

    typedef struct packed {
        date_t date;
        logic  err;
    } step_t;

    localparam date_t DATE_RESET = '{day: DAY_FIRST, month: MON_JAN,
                                     year: '0, weekday: WD_MON};

    // gregorian leap rule: by 4, not by 100 unless by 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [2*YEAR_W-1:0] prod;
        logic                div4;
        logic                div16;
        logic                div25;
        prod  = year * INV25;
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return div4 && (!div25 || div16);
    endfunction

    // days in a month
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MON_FEB)
        begin
            len = leap ? DAY_29 : DAY_28;
        end
        else if (month == MON_APR || month == MON_JUN ||
                 month == MON_SEP || month == MON_NOV)
        begin
            len = DAY_30;
        end
        else
        begin
            len = DAY_31;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

### sv/cds_in_if.sv
// command channel: valid/ready handshake with the step request fields
`default_nettype none

interface cds_in_if;
    import cds_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [DAY_W-1:0]     load_day;
    logic [MONTH_W-1:0]   load_month;
    logic [YEAR_W-1:0]    load_year;
    logic [WEEKDAY_W-1:0] load_weekday;

    modport source (output valid, action, load_day, load_month, load_year,
                    load_weekday, input ready);
    modport sink   (input valid, action, load_day, load_month, load_year,
                    load_weekday, output ready);
endinterface

`default_nettype wire

### sv/cds_out_if.sv
// date channel: valid/ready handshake with the date after each step
`default_nettype none

interface cds_out_if;
    import cds_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DAY_W-1:0]     cur_day;
    logic [MONTH_W-1:0]   cur_month;
    logic [YEAR_W-1:0]    cur_year;
    logic [WEEKDAY_W-1:0] cur_weekday;
    logic                 day_error;

    modport source (output valid, cur_day, cur_month, cur_year, cur_weekday,
                    day_error, input ready);
    modport sink   (input valid, cur_day, cur_month, cur_year, cur_weekday,
                    day_error, output ready);
endinterface

`default_nettype wire

### sv/calendar_date_stepper.sv
// top level of the gregorian calendar date stepper
`default_nettype none

// Gregorian calendar stepper. Each item on cmd advances the held date by one day,
// retreats it by one day, loads a new date or leaves it unchanged, and yields
// exactly one item on date with the date after the step. An accepted item is held
// in the command register, is applied to the date registers through the step logic,
// and lands in the result register; one item per cycle sustained while date.ready
// holds. cmd.ready follows date.ready combinationally through the two stages.
// After reset the date is day 1, January, year 0, Monday.

module calendar_date_stepper (
    input  wire       clk,
    input  wire       rst_n,
    cds_in_if.sink    cmd,
    cds_out_if.source date
);
    import cds_pkg::*;

    logic  cmd_valid_reg;
    cmd_t  cmd_reg;
    date_t date_reg;
    date_t date_next;
    step_t step;
    logic  out_free;
    logic  apply;

    // pipeline flow
    assign apply     = cmd_valid_reg && out_free;
    assign cmd.ready = !cmd_valid_reg || out_free;

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= '{action: cmd.action, load_day: cmd.load_day,
                         load_month: cmd.load_month, load_year: cmd.load_year,
                         load_weekday: cmd.load_weekday};
        end
    end

    // step logic
    cds_step u_step (
        .cur (date_reg),
        .cmd (cmd_reg),
        .res (step)
    );

    // date registers
    assign date_next = apply ? step.date : date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg <= DATE_RESET;
        end
        else
        begin
            date_reg <= date_next;
        end
    end

    // result register
    cds_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (apply),
        .res   (step),
        .free  (out_free),
        .date  (date)
    );

endmodule

`default_nettype wire

### sv/cds_step.sv
// next-date logic: advance, retreat or load applied to the current date
`default_nettype none

module cds_step (
    input  var cds_pkg::date_t cur,
    input  var cds_pkg::cmd_t  cmd,
    output cds_pkg::step_t     res
);
    import cds_pkg::*;

    logic             leap;
    logic [DAY_W-1:0] cur_len;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0] prev_len;

    // month lengths of this month and the one before, same year
    assign leap       = is_leap(cur.year);
    assign cur_len    = month_length(cur.month, leap);
    assign prev_month = cur.month - MONTH_W'(1);
    assign prev_len   = month_length(prev_month, leap);

    always_comb
    begin
        res.date = cur;
        res.err  = 1'b0;
        unique case (cmd.action)
            ACT_ADVANCE:
            begin
                res.date.weekday = (cur.weekday >= WD_SUN) ? WD_MON
                                                           : cur.weekday + WEEKDAY_W'(1);
                if (cur.day < cur_len)
                begin
                    res.date.day = cur.day + DAY_W'(1);
                end
                else if (cur.day == cur_len)
                begin
                    res.date.day = DAY_FIRST;
                    if (cur.month >= MON_DEC)
                    begin
                        res.date.month = MON_JAN;
                        res.date.year  = cur.year + YEAR_W'(1);
                    end
                    else
                    begin
                        res.date.month = cur.month + MONTH_W'(1);
                    end
                end
                else
                begin
                    res.date.day = DAY_FIRST;
                    res.err      = 1'b1;
                end
            end
            ACT_RETREAT:
            begin
                res.date.weekday = (cur.weekday <= WD_MON) ? WD_SUN
                                                           : cur.weekday - WEEKDAY_W'(1);
                if (cur.day >= DAY_W'(2))
                begin
                    res.date.day = cur.day - DAY_W'(1);
                end
                else if (cur.day == DAY_FIRST)
                begin
                    if (cur.month <= MON_JAN)
                    begin
                        // december has 31 days in every year
                        res.date.month = MON_DEC;
                        res.date.year  = cur.year - YEAR_W'(1);
                        res.date.day   = DAY_31;
                    end
                    else
                    begin
                        res.date.month = prev_month;
                        res.date.day   = prev_len;
                    end
                end
                else
                begin
                    res.date.day = DAY_FIRST;
                    res.err      = 1'b1;
                end
            end
            ACT_LOAD:
            begin
                res.date.day  = cmd.load_day;
                res.date.year = cmd.load_year;
                if (cmd.load_month >= MON_JAN && cmd.load_month <= MON_DEC)
                begin
                    res.date.month = cmd.load_month;
                end
                if (cmd.load_weekday != '0)
                begin
                    res.date.weekday = cmd.load_weekday;
                end
            end
            ACT_NONE:
            begin
                res.date = cur;
            end
            default:
            begin
                res.date = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/cds_out_stage.sv
// result register driving the date channel
`default_nettype none

module cds_out_stage (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            load,
    input  var cds_pkg::step_t res,
    output logic           free,
    cds_out_if.source      date
);
    import cds_pkg::*;

    logic  valid_reg;
    step_t res_reg;

    // register can take a new item when empty or being drained
    assign free = !valid_reg || date.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg <= res;
        end
    end

    assign date.valid       = valid_reg;
    assign date.cur_day     = res_reg.date.day;
    assign date.cur_month   = res_reg.date.month;
    assign date.cur_year    = res_reg.date.year;
    assign date.cur_weekday = res_reg.date.weekday;
    assign date.day_error   = res_reg.err;

endmodule

`default_nettype wire

### dv/calendar_date_stepper_tb.sv
// testbench for calendar_date_stepper: directed and random steps checked against a calendar predictor
`timescale 1ns / 100ps

module calendar_date_stepper_tb;
    import cds_pkg::*;

    localparam int LIMIT_NS = 5_000_000;

    // month and weekday codes not named in the package
    localparam logic [MONTH_W-1:0]   MON_BAD_LO = 4'd0;
    localparam logic [MONTH_W-1:0]   MON_MAR    = 4'd3;
    localparam logic [MONTH_W-1:0]   MON_MAY    = 4'd5;
    localparam logic [MONTH_W-1:0]   MON_BAD_HI = 4'd15;
    localparam logic [WEEKDAY_W-1:0] WD_BAD     = 3'd0;

    logic clk = 1'b0;
    logic rst_n;

    cds_in_if  cmd_ch ();
    cds_out_if date_ch ();

    calendar_date_stepper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .date  (date_ch)
    );

    always #5 clk = ~clk;

    // pending items, expected dates and the predictor's own calendar
    cmd_t  pending_cmds[$];
    step_t expected_dates[$];
    date_t cal_date = DATE_RESET;

    int          errors = 0;
    int          idle_pct = 0;
    int unsigned results_seen = 0;
    int unsigned send_idle = 0;
    int unsigned recv_hold = 0;
    logic        long_hold_done = 1'b0;
    cmd_t        next_cmd;
    cmd_t        taken_cmd;
    step_t       want;

    // gregorian leap rule
    function automatic bit leap_year(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] n;
        case (m)
            MON_FEB: n = leap_year(y) ? DAY_29 : DAY_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n = DAY_30;
            default: n = DAY_31;
        endcase
        return n;
    endfunction

    // apply one item to the calendar and return the date it should show
    function automatic step_t step_calendar(input cmd_t c);
        step_t            r;
        logic [DAY_W-1:0] len;
        logic             err;
        err = 1'b0;
        case (c.action)
            ACT_ADVANCE:
            begin
                len = days_in(cal_date.month, cal_date.year);
                cal_date.weekday = (cal_date.weekday >= WD_SUN) ? WD_MON : cal_date.weekday + 3'd1;
                if (cal_date.day < len)
                begin
                    cal_date.day = cal_date.day + 5'd1;
                end
                else if (cal_date.day == len)
                begin
                    cal_date.day = DAY_FIRST;
                    if (cal_date.month >= MON_DEC)
                    begin
                        cal_date.month = MON_JAN;
                        cal_date.year  = cal_date.year + 16'd1;
                    end
                    else
                    begin
                        cal_date.month = cal_date.month + 4'd1;
                    end
                end
                else
                begin
                    cal_date.day = DAY_FIRST;
                    err = 1'b1;
                end
            end
            ACT_RETREAT:
            begin
                cal_date.weekday = (cal_date.weekday <= WD_MON) ? WD_SUN : cal_date.weekday - 3'd1;
                if (cal_date.day >= 5'd2)
                begin
                    cal_date.day = cal_date.day - 5'd1;
                end
                else if (cal_date.day == DAY_FIRST)
                begin
                    if (cal_date.month <= MON_JAN)
                    begin
                        cal_date.month = MON_DEC;
                        cal_date.year  = cal_date.year - 16'd1;
                    end
                    else
                    begin
                        cal_date.month = cal_date.month - 4'd1;
                    end
                    cal_date.day = days_in(cal_date.month, cal_date.year);
                end
                else
                begin
                    cal_date.day = DAY_FIRST;
                    err = 1'b1;
                end
            end
            ACT_LOAD:
            begin
                cal_date.day  = c.load_day;
                cal_date.year = c.load_year;
                if (c.load_month >= MON_JAN && c.load_month <= MON_DEC)
                begin
                    cal_date.month = c.load_month;
                end
                if (c.load_weekday >= WD_MON && c.load_weekday <= WD_SUN)
                begin
                    cal_date.weekday = c.load_weekday;
                end
            end
            default:
            begin
            end
        endcase
        r.date = cal_date;
        r.err  = err;
        return r;
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [DAY_W-1:0] d,
                              input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y,
                              input logic [WEEKDAY_W-1:0] w);
        cmd_t c;
        c = '{action: act, load_day: d, load_month: m, load_year: y, load_weekday: w};
        pending_cmds.push_back(c);
    endtask

    // step item with junk in the load fields
    task automatic queue_step(input logic [ACTION_W-1:0] act);
        queue_item(act, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom),
                   WEEKDAY_W'($urandom));
    endtask

    // years around the leap rule corners and the wrap, plus fully random years
    function automatic logic [YEAR_W-1:0] rand_year();
        logic [YEAR_W-1:0] y;
        case ($urandom_range(0, 5))
            0: y = YEAR_W'($urandom);
            1: y = YEAR_W'(100 * $urandom_range(0, 655));
            2: y = YEAR_W'(400 * $urandom_range(0, 163));
            3: y = YEAR_W'(4 * $urandom_range(0, 16383));
            4: y = ($urandom_range(0, 1) == 0) ? YEAR_W'($urandom_range(0, 4))
                                               : 16'hFFFF - YEAR_W'($urandom_range(0, 4));
            default: y = YEAR_W'($urandom_range(1896, 2104));
        endcase
        return y;
    endfunction

    // mostly valid loads near a month edge followed by runs of steps
    task automatic queue_random(input int count);
        int                    made;
        int                    run;
        int                    kind;
        logic [MONTH_W-1:0]    m;
        logic [YEAR_W-1:0]     y;
        logic [DAY_W-1:0]      d;
        logic [ACTION_W-1:0]   dir;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                if ($urandom_range(0, 2) == 0)
                    m = ($urandom_range(0, 1) == 0) ? MON_JAN : MON_DEC;
                else
                    m = MONTH_W'($urandom_range(1, 12));
                y = rand_year();
                if ($urandom_range(0, 1) == 0)
                begin
                    d   = days_in(m, y) - DAY_W'($urandom_range(0, 2));
                    dir = ACT_ADVANCE;
                end
                else
                begin
                    d   = DAY_W'($urandom_range(1, 3));
                    dir = ACT_RETREAT;
                end
                queue_item(ACT_LOAD, d, m, y, WEEKDAY_W'($urandom_range(1, 7)));
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 400)
                                                   : $urandom_range(1, 8);
                repeat (run)
                    queue_step(($urandom_range(0, 7) == 0) ? ACTION_W'($urandom_range(0, 1)) : dir);
                made += run + 1;
            end
            else if (kind < 80)
            begin
                queue_item(ACT_LOAD, DAY_W'($urandom), MONTH_W'($urandom),
                           YEAR_W'($urandom), WEEKDAY_W'($urandom));
                made++;
            end
            else if (kind < 88)
            begin
                queue_step(ACT_NONE);
            end
            else
            begin
                queue_step(($urandom_range(0, 1) == 0) ? ACT_ADVANCE : ACT_RETREAT);
                made++;
            end
        end
    endtask

    // sender idle until everything queued is through the block
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_dates.size() != 0)
            @(negedge clk);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.action       <= ACT_ADVANCE;
            cmd_ch.load_day     <= '0;
            cmd_ch.load_month   <= '0;
            cmd_ch.load_year    <= '0;
            cmd_ch.load_weekday <= '0;
            send_idle           <= 0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (send_idle != 0)
            begin
                send_idle    <= send_idle - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_idle    <= $urandom_range(0, 11);
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd_ch.action       <= next_cmd.action;
                cmd_ch.load_day     <= next_cmd.load_day;
                cmd_ch.load_month   <= next_cmd.load_month;
                cmd_ch.load_year    <= next_cmd.load_year;
                cmd_ch.load_weekday <= next_cmd.load_weekday;
                cmd_ch.valid        <= 1'b1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // date receiver: random stalls plus one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_ch.ready <= 1'b0;
            recv_hold     <= 0;
        end
        else if (recv_hold != 0)
        begin
            recv_hold     <= recv_hold - 1;
            date_ch.ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 300)
        begin
            long_hold_done <= 1'b1;
            recv_hold      <= 60;
            date_ch.ready  <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            recv_hold     <= $urandom_range(0, 11);
            date_ch.ready <= 1'b0;
        end
        else
        begin
            date_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted command, check each accepted date
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken_cmd = '{action: cmd_ch.action, load_day: cmd_ch.load_day,
                              load_month: cmd_ch.load_month, load_year: cmd_ch.load_year,
                              load_weekday: cmd_ch.load_weekday};
                expected_dates.push_back(step_calendar(taken_cmd));
            end
            if (date_ch.valid && date_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_dates.size() == 0)
                begin
                    $error("date item with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (date_ch.cur_day !== want.date.day)
                    begin
                        $error("cur_day: expected %0d, got %0d", want.date.day, date_ch.cur_day);
                        errors++;
                    end
                    if (date_ch.cur_month !== want.date.month)
                    begin
                        $error("cur_month: expected %0d, got %0d", want.date.month,
                               date_ch.cur_month);
                        errors++;
                    end
                    if (date_ch.cur_year !== want.date.year)
                    begin
                        $error("cur_year: expected %0d, got %0d", want.date.year,
                               date_ch.cur_year);
                        errors++;
                    end
                    if (date_ch.cur_weekday !== want.date.weekday)
                    begin
                        $error("cur_weekday: expected %0d, got %0d", want.date.weekday,
                               date_ch.cur_weekday);
                        errors++;
                    end
                    if (date_ch.day_error !== want.err)
                    begin
                        $error("day_error: expected %0d, got %0d", want.err,
                               date_ch.day_error);
                        errors++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n <= 1'b0;
        idle_pct = 20;

        // unused action, both wraps, leap rule corners, bad days and bad load codes
        queue_item(ACT_NONE, DAY_31, MON_BAD_HI, 16'hFFFF, WD_SUN);
        queue_step(ACT_RETREAT);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, DAY_28, MON_FEB, 16'd1900, 3'd3);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, DAY_28, MON_FEB, 16'd2000, WD_SUN);
        queue_step(ACT_ADVANCE);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, DAY_29, MON_FEB, 16'd1900, WD_MON);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, 5'd0, MON_MAY, 16'd2023, 3'd2);
        queue_step(ACT_RETREAT);
        queue_item(ACT_LOAD, 5'd0, MON_JUN, 16'd2023, 3'd2);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, DAY_31, MON_APR, 16'd2023, 3'd4);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, 5'd15, MON_BAD_LO, 16'd1234, WD_BAD);
        queue_item(ACT_LOAD, DAY_30, MON_BAD_HI, 16'd1234, 3'd6);
        queue_step(ACT_ADVANCE);
        queue_item(ACT_LOAD, DAY_FIRST, MON_MAR, 16'd2024, 3'd5);
        queue_step(ACT_RETREAT);
        queue_item(ACT_LOAD, DAY_FIRST, MON_MAR, 16'd2100, 3'd5);
        queue_step(ACT_RETREAT);
        queue_item(ACT_LOAD, DAY_31, MON_DEC, 16'hFFFF, WD_SUN);
        queue_step(ACT_ADVANCE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        idle_pct = 25;
        queue_random(500);
        wait_drained();

        idle_pct = 10;
        queue_random(450);
        wait_drained();

        // closing stretch at full rate on both sides
        idle_pct = 0;
        queue_random(275);
        wait_drained();

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("calendar_date_stepper_tb: clean");
        else
            $display("calendar_date_stepper_tb: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(LIMIT_NS);
        $display("calendar_date_stepper_tb: errors");
        $finish;
    end

endmodule
